>>> src/miu_pkg.sv
// Package with opcodes, function codes and shared types for the integer execute unit.
package miu_pkg;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2B;

  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1A;
  localparam logic [5:0] FN_DIVU    = 6'h1B;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2A;

  localparam logic [4:0] RT_BLTZ = 5'd0;
  localparam logic [4:0] RT_BGEZ = 5'd1;
  localparam logic [4:0] REG_RA  = 5'd31;

  localparam logic [2:0] MEM_NONE = 3'd0;
  localparam logic [2:0] MEM_LB   = 3'd1;
  localparam logic [2:0] MEM_LH   = 3'd2;
  localparam logic [2:0] MEM_LW   = 3'd3;
  localparam logic [2:0] MEM_SB   = 3'd4;
  localparam logic [2:0] MEM_SH   = 3'd5;
  localparam logic [2:0] MEM_SW   = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV_PREP,
    ST_DIV_RUN,
    ST_DIV_FIX,
    ST_OUT
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;       // capture input word and decode
    logic mul_lo;     // magnitudes and low partial product
    logic mul_hi;     // high partial products and write HI/LO
    logic div_prep;   // take magnitudes
    logic div_step;   // one quotient bit
    logic div_fix;    // sign fix and write HI/LO
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic is_mul;
    logic is_div;
    logic div_last;
  } stat_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic [4:0]  dest_reg;
    logic        reg_write;
    logic        branch_taken;
    logic [31:0] next_pc;
    logic [2:0]  mem_op;
    logic [31:0] mem_address;
    logic [31:0] store_data;
    logic        syscall_seen;
    logic        unimplemented;
  } result_t;

endpackage

>>> src/miu_if.sv
// Valid/ready channel interfaces for instruction words and result words.
interface miu_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr;
  logic [31:0] rs_value;
  logic [31:0] rt_value;
  logic [31:0] pc;
  modport source (output valid, output instr, output rs_value, output rt_value, output pc,
                  input ready);
  modport sink (input valid, input instr, input rs_value, input rt_value, input pc,
                output ready);
endinterface

interface miu_out_if;
  logic              valid;
  logic              ready;
  miu_pkg::result_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/miu_ctrl.sv
// Controller state machine sequencing decode, multiply, divide and output.
module miu_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  miu_pkg::stat_t  stat,
  output miu_pkg::cmd_t   cmd
);

  miu_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= miu_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      miu_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = miu_pkg::ST_OUT;
        end
      end
      miu_pkg::ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = miu_pkg::ST_MUL_HI;
      end
      miu_pkg::ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = miu_pkg::ST_IDLE;
      end
      miu_pkg::ST_DIV_PREP: begin
        cmd.div_prep = 1'b1;
        state_nxt    = miu_pkg::ST_DIV_RUN;
      end
      miu_pkg::ST_DIV_RUN: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = miu_pkg::ST_DIV_FIX;
        end
      end
      miu_pkg::ST_DIV_FIX: begin
        cmd.div_fix = 1'b1;
        state_nxt   = miu_pkg::ST_IDLE;
      end
      miu_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (stat.is_mul) begin
            state_nxt = miu_pkg::ST_MUL_LO;
          end else if (stat.is_div) begin
            state_nxt = miu_pkg::ST_DIV_PREP;
          end else begin
            state_nxt = miu_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = miu_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> src/miu_dp.sv
// Datapath: decode, ALU, branch and address logic, multiplier, divider, HI/LO.
module miu_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [31:0]      instr,
  input  logic [31:0]      rs_value,
  input  logic [31:0]      rt_value,
  input  logic [31:0]      pc,
  input  miu_pkg::cmd_t    cmd,
  output miu_pkg::stat_t   stat,
  output miu_pkg::result_t res
);

  logic [31:0] hi_r, hi_nxt, lo_r, lo_nxt;
  logic [31:0] a_r, b_r;
  logic        is_mul_r, is_div_r, signed_r;
  logic        is_mul_nxt, is_div_nxt;
  miu_pkg::result_t res_r, res_nxt;

  // Multiplier: four 16x16 partial products on magnitudes, over MUL_LO and MUL_HI.
  logic [31:0] ma_r, mb_r, ma_nxt, mb_nxt;
  logic        mneg_r;
  logic [63:0] macc_r;
  logic [31:0] pp_ll, pp_lh, pp_hl, pp_hh;
  logic [63:0] prod_mag;

  // Divider: restoring, one quotient bit per cycle.
  logic [31:0] dq_r, drem_r, dd_r;
  logic        qneg_r, rneg_r;
  logic [4:0]  dcnt_r;
  logic [33:0] dtrial;
  logic [32:0] drem_sh;

  logic [5:0]  op, fn;
  logic [4:0]  rt, rd, sa;
  logic [15:0] imm;
  logic [31:0] simm, link, btgt, jtgt, sum_i;
  logic        bad;

  always_comb begin
    op   = instr[31:26];
    rt   = instr[20:16];
    rd   = instr[15:11];
    sa   = instr[10:6];
    fn   = instr[5:0];
    imm  = instr[15:0];
    simm = {{16{imm[15]}}, imm};
    link = pc + 32'd4;
    btgt = link + {simm[29:0], 2'b00};
    jtgt = {link[31:28], instr[25:0], 2'b00};
    sum_i = rs_value + simm;
    res_nxt = '0;
    bad = 1'b0;
    is_mul_nxt = 1'b0;
    is_div_nxt = 1'b0;
    hi_nxt = hi_r;
    lo_nxt = lo_r;
    if (op == miu_pkg::OP_SPECIAL) begin
      res_nxt.dest_reg  = rd;
      res_nxt.reg_write = 1'b1;
      case (fn)
        miu_pkg::FN_SLL: res_nxt.result_value = rt_value << sa;
        miu_pkg::FN_SRL: res_nxt.result_value = rt_value >> sa;
        miu_pkg::FN_SRA: res_nxt.result_value = $unsigned($signed(rt_value) >>> sa);
        miu_pkg::FN_JR: begin
          res_nxt.reg_write = 1'b0; res_nxt.dest_reg = '0;
          res_nxt.branch_taken = 1'b1; res_nxt.next_pc = rs_value;
        end
        miu_pkg::FN_JALR: begin
          res_nxt.result_value = link;
          res_nxt.branch_taken = 1'b1; res_nxt.next_pc = rs_value;
        end
        miu_pkg::FN_SYSCALL: begin
          res_nxt.reg_write = 1'b0; res_nxt.dest_reg = '0; res_nxt.syscall_seen = 1'b1;
        end
        miu_pkg::FN_MFHI: res_nxt.result_value = hi_r;
        miu_pkg::FN_MFLO: res_nxt.result_value = lo_r;
        miu_pkg::FN_MTHI: begin
          res_nxt.reg_write = 1'b0; res_nxt.dest_reg = '0; hi_nxt = rs_value;
        end
        miu_pkg::FN_MTLO: begin
          res_nxt.reg_write = 1'b0; res_nxt.dest_reg = '0; lo_nxt = rs_value;
        end
        miu_pkg::FN_MULT, miu_pkg::FN_MULTU: begin
          res_nxt.reg_write = 1'b0; res_nxt.dest_reg = '0; is_mul_nxt = 1'b1;
        end
        miu_pkg::FN_DIV, miu_pkg::FN_DIVU: begin
          res_nxt.reg_write = 1'b0; res_nxt.dest_reg = '0;
          is_div_nxt = (rt_value != 32'd0);
        end
        miu_pkg::FN_ADD, miu_pkg::FN_ADDU: res_nxt.result_value = rs_value + rt_value;
        miu_pkg::FN_SUB, miu_pkg::FN_SUBU: res_nxt.result_value = rs_value - rt_value;
        miu_pkg::FN_AND: res_nxt.result_value = rs_value & rt_value;
        miu_pkg::FN_OR:  res_nxt.result_value = rs_value | rt_value;
        miu_pkg::FN_XOR: res_nxt.result_value = rs_value ^ rt_value;
        miu_pkg::FN_NOR: res_nxt.result_value = ~(rs_value | rt_value);
        miu_pkg::FN_SLT:
          res_nxt.result_value = {31'd0, $signed(rs_value) < $signed(rt_value)};
        default: bad = 1'b1;
      endcase
    end else begin
      case (op)
        miu_pkg::OP_REGIMM: begin
          res_nxt.next_pc = btgt;
          if (rt == miu_pkg::RT_BLTZ) begin
            res_nxt.branch_taken = rs_value[31];
          end else if (rt == miu_pkg::RT_BGEZ) begin
            res_nxt.branch_taken = !rs_value[31];
          end else begin
            bad = 1'b1;
          end
        end
        miu_pkg::OP_J: begin
          res_nxt.branch_taken = 1'b1; res_nxt.next_pc = jtgt;
        end
        miu_pkg::OP_JAL: begin
          res_nxt.branch_taken = 1'b1; res_nxt.next_pc = jtgt;
          res_nxt.result_value = link; res_nxt.dest_reg = miu_pkg::REG_RA;
          res_nxt.reg_write = 1'b1;
        end
        miu_pkg::OP_BEQ: begin
          res_nxt.next_pc = btgt; res_nxt.branch_taken = (rs_value == rt_value);
        end
        miu_pkg::OP_BNE: begin
          res_nxt.next_pc = btgt; res_nxt.branch_taken = (rs_value != rt_value);
        end
        miu_pkg::OP_BLEZ: begin
          res_nxt.next_pc = btgt;
          res_nxt.branch_taken = rs_value[31] || (rs_value == 32'd0);
        end
        miu_pkg::OP_BGTZ: begin
          res_nxt.next_pc = btgt;
          res_nxt.branch_taken = !rs_value[31] && (rs_value != 32'd0);
        end
        miu_pkg::OP_ADDI, miu_pkg::OP_ADDIU: begin
          res_nxt.result_value = sum_i; res_nxt.dest_reg = rt; res_nxt.reg_write = 1'b1;
        end
        miu_pkg::OP_SLTI: begin
          res_nxt.result_value = {31'd0, $signed(rs_value) < $signed(simm)};
          res_nxt.dest_reg = rt; res_nxt.reg_write = 1'b1;
        end
        miu_pkg::OP_ANDI: begin
          res_nxt.result_value = rs_value & {16'd0, imm};
          res_nxt.dest_reg = rt; res_nxt.reg_write = 1'b1;
        end
        miu_pkg::OP_ORI: begin
          res_nxt.result_value = rs_value | {16'd0, imm};
          res_nxt.dest_reg = rt; res_nxt.reg_write = 1'b1;
        end
        miu_pkg::OP_XORI: begin
          res_nxt.result_value = rs_value ^ {16'd0, imm};
          res_nxt.dest_reg = rt; res_nxt.reg_write = 1'b1;
        end
        miu_pkg::OP_LUI: begin
          res_nxt.result_value = {imm, 16'd0};
          res_nxt.dest_reg = rt; res_nxt.reg_write = 1'b1;
        end
        miu_pkg::OP_LB, miu_pkg::OP_LH, miu_pkg::OP_LW: begin
          res_nxt.mem_op = (op == miu_pkg::OP_LB) ? miu_pkg::MEM_LB :
                           (op == miu_pkg::OP_LH) ? miu_pkg::MEM_LH : miu_pkg::MEM_LW;
          res_nxt.mem_address = sum_i; res_nxt.dest_reg = rt; res_nxt.reg_write = 1'b1;
        end
        miu_pkg::OP_SB: begin
          res_nxt.mem_op = miu_pkg::MEM_SB; res_nxt.mem_address = sum_i;
          res_nxt.store_data = {24'd0, rt_value[7:0]};
        end
        miu_pkg::OP_SH: begin
          res_nxt.mem_op = miu_pkg::MEM_SH; res_nxt.mem_address = sum_i;
          res_nxt.store_data = {16'd0, rt_value[15:0]};
        end
        miu_pkg::OP_SW: begin
          res_nxt.mem_op = miu_pkg::MEM_SW; res_nxt.mem_address = sum_i;
          res_nxt.store_data = rt_value;
        end
        default: bad = 1'b1;
      endcase
    end
    if (bad) begin
      res_nxt = '0;
      res_nxt.unimplemented = 1'b1;
      hi_nxt = hi_r;
      lo_nxt = lo_r;
    end
  end

  // Magnitudes, low partial product, divider step and final multiply sum.
  always_comb begin
    ma_nxt   = (signed_r && a_r[31]) ? (32'd0 - a_r) : a_r;
    mb_nxt   = (signed_r && b_r[31]) ? (32'd0 - b_r) : b_r;
    pp_ll    = 32'(ma_nxt[15:0]) * 32'(mb_nxt[15:0]);
    pp_lh    = 32'(ma_r[15:0]) * 32'(mb_r[31:16]);
    pp_hl    = 32'(ma_r[31:16]) * 32'(mb_r[15:0]);
    pp_hh    = 32'(ma_r[31:16]) * 32'(mb_r[31:16]);
    drem_sh  = {drem_r, dq_r[31]};
    dtrial   = {1'b0, drem_sh} - {2'b00, dd_r};
    prod_mag = macc_r + ({32'd0, pp_hl} << 16) + ({32'd0, pp_lh} << 16)
             + {pp_hh, 32'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_r <= '0;
      lo_r <= '0;
      is_mul_r <= 1'b0;
      is_div_r <= 1'b0;
    end else if (cmd.load) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
      is_mul_r <= is_mul_nxt;
      is_div_r <= is_div_nxt;
    end else if (cmd.mul_hi) begin
      hi_r <= mneg_r ? (~prod_mag[63:32] + {31'd0, prod_mag[31:0] == 32'd0})
                     : prod_mag[63:32];
      lo_r <= mneg_r ? (~prod_mag[31:0] + 32'd1) : prod_mag[31:0];
    end else if (cmd.div_fix) begin
      lo_r <= qneg_r ? (32'd0 - dq_r) : dq_r;
      hi_r <= rneg_r ? (32'd0 - drem_r) : drem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_r    <= res_nxt;
      a_r      <= rs_value;
      b_r      <= rt_value;
      signed_r <= (fn == miu_pkg::FN_MULT) || (fn == miu_pkg::FN_DIV);
    end
    if (cmd.mul_lo) begin
      ma_r   <= ma_nxt;
      mb_r   <= mb_nxt;
      mneg_r <= signed_r && (a_r[31] ^ b_r[31]);
    end
    if (cmd.div_prep) begin
      dq_r   <= ma_nxt;
      dd_r   <= mb_nxt;
      drem_r <= '0;
      dcnt_r <= '0;
      qneg_r <= signed_r && (a_r[31] ^ b_r[31]);
      rneg_r <= signed_r && a_r[31];
    end
    if (cmd.div_step) begin
      dcnt_r <= dcnt_r + 5'd1;
      if (!dtrial[33]) begin
        drem_r <= dtrial[31:0];
        dq_r   <= {dq_r[30:0], 1'b1};
      end else begin
        drem_r <= drem_sh[31:0];
        dq_r   <= {dq_r[30:0], 1'b0};
      end
    end
  end

  // The low partial product is taken together with the magnitudes; the other
  // three are added in the following cycle.
  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      macc_r <= {32'd0, pp_ll};
    end
  end

  always_comb begin
    stat.is_mul   = is_mul_r;
    stat.is_div   = is_div_r;
    stat.div_last = (dcnt_r == 5'd31);
    res           = res_r;
  end

endmodule

>>> src/mips_integer_execute_unit.sv
// Top level of the MIPS32 integer execute unit.
// Usage: one instruction word (instr, rs_value, rt_value, pc) enters on the in_
// channel when in_valid and in_ready are both high. Exactly one result word leaves
// on the out_ channel when out_valid and out_ready are both high.
// The result is presented in the cycle after the input is taken, and for an
// ordinary instruction the unit is ready again in the cycle after the result
// is taken; an output stall holds the unit in between.
// MULT and MULTU update HI/LO through a 16x16 partial-product multiplier in
// the states MUL_LO and MUL_HI after their result word leaves; DIV and DIVU with
// a nonzero divisor run a restoring divider, one quotient bit per cycle, through
// DIV_PREP, DIV_RUN and DIV_FIX. The unit takes no new word until HI/LO are
// written, so a following MFHI or MFLO always sees the new value.
// Reset (rst_n low, synchronous) clears HI, LO and the controller; the unit
// is ready as soon as reset is released. When the receiver holds out_ready
// low, the result word stays stable and no new input is taken.
module mips_integer_execute_unit (
  input logic clk,
  input logic rst_n,
  miu_in_if.sink    in_ch,
  miu_out_if.source out_ch
);

  miu_pkg::cmd_t  cmd;
  miu_pkg::stat_t stat;

  miu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  miu_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .instr    (in_ch.instr),
    .rs_value (in_ch.rs_value),
    .rt_value (in_ch.rt_value),
    .pc       (in_ch.pc),
    .cmd      (cmd),
    .stat     (stat),
    .res      (out_ch.data)
  );

endmodule

>>> verif/miu_tb_if.sv
// Testbench types: the instruction word as the bench sends it.
`timescale 1ns / 100ps
package miu_tb_types;
  typedef struct {
    logic [31:0] instr;
    logic [31:0] rs_value;
    logic [31:0] rt_value;
    logic [31:0] pc;
  } instr_word_t;
endpackage

>>> verif/tb_top.sv
// Testbench for the MIPS32 integer execute unit: random and directed instruction words.
`timescale 1ns / 100ps
module tb_top;

  class exec_scoreboard;
    logic [31:0] hi_q, lo_q;
    miu_pkg::result_t pending[$];
    int mismatches;
    int checked;

    function void clear_state();
      hi_q = '0;
      lo_q = '0;
    endfunction

    function logic [31:0] sext(logic [15:0] v);
      return {{16{v[15]}}, v};
    endfunction

    // Predicts the result word of one instruction and updates HI/LO.
    function void note_instr(miu_tb_types::instr_word_t w);
      miu_pkg::result_t r;
      logic [5:0] op, fn;
      logic [4:0] rt, rd, sa;
      logic [31:0] a, b, simm, link, btgt, jtgt;
      logic [63:0] prod;
      logic bad;
      op = w.instr[31:26]; fn = w.instr[5:0];
      rt = w.instr[20:16]; rd = w.instr[15:11]; sa = w.instr[10:6];
      a = w.rs_value; b = w.rt_value;
      simm = sext(w.instr[15:0]);
      link = w.pc + 32'd4;
      btgt = link + (simm << 2);
      jtgt = (link & 32'hF000_0000) | {4'b0, w.instr[25:0], 2'b00};
      r = '0;
      bad = 1'b0;
      if (op == miu_pkg::OP_SPECIAL) begin
        r.dest_reg = rd;
        r.reg_write = 1'b1;
        case (fn)
          miu_pkg::FN_SLL: r.result_value = b << sa;
          miu_pkg::FN_SRL: r.result_value = b >> sa;
          miu_pkg::FN_SRA: r.result_value = $signed(b) >>> sa;
          miu_pkg::FN_JR: begin
            r.reg_write = 0; r.dest_reg = 0; r.branch_taken = 1; r.next_pc = a;
          end
          miu_pkg::FN_JALR: begin
            r.result_value = link; r.branch_taken = 1; r.next_pc = a;
          end
          miu_pkg::FN_SYSCALL: begin
            r.reg_write = 0; r.dest_reg = 0; r.syscall_seen = 1;
          end
          miu_pkg::FN_MFHI: r.result_value = hi_q;
          miu_pkg::FN_MFLO: r.result_value = lo_q;
          miu_pkg::FN_MTHI: begin r.reg_write = 0; r.dest_reg = 0; hi_q = a; end
          miu_pkg::FN_MTLO: begin r.reg_write = 0; r.dest_reg = 0; lo_q = a; end
          miu_pkg::FN_MULT, miu_pkg::FN_MULTU: begin
            r.reg_write = 0; r.dest_reg = 0;
            if (fn == miu_pkg::FN_MULT)
              prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
            else prod = {32'b0, a} * {32'b0, b};
            lo_q = prod[31:0]; hi_q = prod[63:32];
          end
          miu_pkg::FN_DIV: begin
            r.reg_write = 0; r.dest_reg = 0;
            if (b != 0) begin
              if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
                lo_q = 32'h8000_0000; hi_q = 0;
              end else begin
                lo_q = $signed(a) / $signed(b);
                hi_q = $signed(a) % $signed(b);
              end
            end
          end
          miu_pkg::FN_DIVU: begin
            r.reg_write = 0; r.dest_reg = 0;
            if (b != 0) begin lo_q = a / b; hi_q = a % b; end
          end
          miu_pkg::FN_ADD, miu_pkg::FN_ADDU: r.result_value = a + b;
          miu_pkg::FN_SUB, miu_pkg::FN_SUBU: r.result_value = a - b;
          miu_pkg::FN_AND: r.result_value = a & b;
          miu_pkg::FN_OR: r.result_value = a | b;
          miu_pkg::FN_XOR: r.result_value = a ^ b;
          miu_pkg::FN_NOR: r.result_value = ~(a | b);
          miu_pkg::FN_SLT: r.result_value = {31'b0, $signed(a) < $signed(b)};
          default: bad = 1'b1;
        endcase
      end else begin
        case (op)
          miu_pkg::OP_REGIMM: begin
            r.next_pc = btgt;
            if (rt == miu_pkg::RT_BLTZ) r.branch_taken = a[31];
            else if (rt == miu_pkg::RT_BGEZ) r.branch_taken = !a[31];
            else bad = 1'b1;
          end
          miu_pkg::OP_J: begin r.branch_taken = 1; r.next_pc = jtgt; end
          miu_pkg::OP_JAL: begin
            r.branch_taken = 1; r.next_pc = jtgt; r.result_value = link;
            r.dest_reg = miu_pkg::REG_RA; r.reg_write = 1;
          end
          miu_pkg::OP_BEQ: begin r.next_pc = btgt; r.branch_taken = (a == b); end
          miu_pkg::OP_BNE: begin r.next_pc = btgt; r.branch_taken = (a != b); end
          miu_pkg::OP_BLEZ: begin r.next_pc = btgt; r.branch_taken = a[31] || a == 0; end
          miu_pkg::OP_BGTZ: begin r.next_pc = btgt; r.branch_taken = !a[31] && a != 0; end
          miu_pkg::OP_ADDI, miu_pkg::OP_ADDIU, miu_pkg::OP_SLTI, miu_pkg::OP_ANDI,
          miu_pkg::OP_ORI, miu_pkg::OP_XORI, miu_pkg::OP_LUI: begin
            r.dest_reg = rt; r.reg_write = 1;
            case (op)
              miu_pkg::OP_SLTI: r.result_value = {31'b0, $signed(a) < $signed(simm)};
              miu_pkg::OP_ANDI: r.result_value = a & {16'b0, w.instr[15:0]};
              miu_pkg::OP_ORI: r.result_value = a | {16'b0, w.instr[15:0]};
              miu_pkg::OP_XORI: r.result_value = a ^ {16'b0, w.instr[15:0]};
              miu_pkg::OP_LUI: r.result_value = {w.instr[15:0], 16'b0};
              default: r.result_value = a + simm;
            endcase
          end
          miu_pkg::OP_LB, miu_pkg::OP_LH, miu_pkg::OP_LW: begin
            r.mem_op = (op == miu_pkg::OP_LB) ? miu_pkg::MEM_LB :
                       (op == miu_pkg::OP_LH) ? miu_pkg::MEM_LH : miu_pkg::MEM_LW;
            r.mem_address = a + simm; r.dest_reg = rt; r.reg_write = 1;
          end
          miu_pkg::OP_SB: begin
            r.mem_op = miu_pkg::MEM_SB; r.mem_address = a + simm; r.store_data = b & 32'hFF;
          end
          miu_pkg::OP_SH: begin
            r.mem_op = miu_pkg::MEM_SH; r.mem_address = a + simm;
            r.store_data = b & 32'hFFFF;
          end
          miu_pkg::OP_SW: begin
            r.mem_op = miu_pkg::MEM_SW; r.mem_address = a + simm; r.store_data = b;
          end
          default: bad = 1'b1;
        endcase
      end
      if (bad) begin
        r = '0;
        r.unimplemented = 1'b1;
      end
      pending.push_back(r);
    endfunction

    function void check_result(miu_pkg::result_t got);
      miu_pkg::result_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: exp res=%h dst=%0d wr=%b tk=%b npc=%h mop=%0d adr=%h sd=%h %s",
                   exp_r.result_value, exp_r.dest_reg, exp_r.reg_write, exp_r.branch_taken,
                   exp_r.next_pc, exp_r.mem_op, exp_r.mem_address, exp_r.store_data,
                   $sformatf("sys=%b u=%b", exp_r.syscall_seen, exp_r.unimplemented));
          $display("          got res=%h dst=%0d wr=%b tk=%b npc=%h mop=%0d adr=%h sd=%h %s",
                   got.result_value, got.dest_reg, got.reg_write, got.branch_taken,
                   got.next_pc, got.mem_op, got.mem_address, got.store_data,
                   $sformatf("sys=%b u=%b", got.syscall_seen, got.unimplemented));
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  miu_in_if in_ch ();
  miu_out_if out_ch ();
  exec_scoreboard sb;

  int send_idle_pct = 37;
  int recv_idle_pct = 72;
  bit recv_hold = 1'b0;
  int sent = 0;

  mips_integer_execute_unit u_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.instr = '0;
    in_ch.rs_value = '0;
    in_ch.rt_value = '0;
    in_ch.pc = '0;
    out_ch.ready = 1'b0;
  end

  // Receiver: random ready, with a forced hold-off window.
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(16) - 8;
      default: return $urandom;
    endcase
  endfunction

  // Sends one word, holding it until the unit accepts it. Valid stays high
  // after the accept so a following word can go out back to back.
  task automatic send_word(logic [31:0] ins, logic [31:0] a, logic [31:0] b, logic [31:0] p);
    miu_tb_types::instr_word_t w;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.instr <= ins;
    in_ch.rs_value <= a;
    in_ch.rt_value <= b;
    in_ch.pc <= p;
    w.instr = ins; w.rs_value = a; w.rt_value = b; w.pc = p;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_instr(w);
    sent++;
  endtask

  task automatic send_random();
    logic [5:0] ops[] = '{miu_pkg::OP_SPECIAL, miu_pkg::OP_SPECIAL, miu_pkg::OP_SPECIAL,
                          miu_pkg::OP_REGIMM, miu_pkg::OP_J, miu_pkg::OP_JAL,
                          miu_pkg::OP_BEQ, miu_pkg::OP_BNE, miu_pkg::OP_BLEZ,
                          miu_pkg::OP_BGTZ, miu_pkg::OP_ADDI, miu_pkg::OP_ADDIU,
                          miu_pkg::OP_SLTI, miu_pkg::OP_ANDI, miu_pkg::OP_ORI,
                          miu_pkg::OP_XORI, miu_pkg::OP_LUI, miu_pkg::OP_LB,
                          miu_pkg::OP_LH, miu_pkg::OP_LW, miu_pkg::OP_SB,
                          miu_pkg::OP_SH, miu_pkg::OP_SW};
    logic [5:0] fns[] = '{miu_pkg::FN_SLL, miu_pkg::FN_SRL, miu_pkg::FN_SRA,
                          miu_pkg::FN_JR, miu_pkg::FN_JALR, miu_pkg::FN_SYSCALL,
                          miu_pkg::FN_MFHI, miu_pkg::FN_MTHI, miu_pkg::FN_MFLO,
                          miu_pkg::FN_MTLO, miu_pkg::FN_MULT, miu_pkg::FN_MULTU,
                          miu_pkg::FN_DIV, miu_pkg::FN_DIVU, miu_pkg::FN_ADD,
                          miu_pkg::FN_ADDU, miu_pkg::FN_SUB, miu_pkg::FN_SUBU,
                          miu_pkg::FN_AND, miu_pkg::FN_OR, miu_pkg::FN_XOR,
                          miu_pkg::FN_NOR, miu_pkg::FN_SLT};
    logic [31:0] ins, b;
    ins = $urandom;
    if ($urandom_range(19) != 0) begin
      ins[31:26] = ops[$urandom_range(ops.size() - 1)];
      if (ins[31:26] == miu_pkg::OP_SPECIAL) ins[5:0] = fns[$urandom_range(fns.size() - 1)];
      if (ins[31:26] == miu_pkg::OP_REGIMM && $urandom_range(3) != 0)
        ins[20:16] = 5'($urandom_range(1));
    end
    b = rand_operand();
    send_word(ins, rand_operand(), b, $urandom);
  endtask

  task automatic drain();
    int guard;
    in_ch.valid <= 1'b0;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    // Divides keep working for a while after their result word leaves.
    repeat (40) @(posedge clk);
  endtask

  initial begin
    sb = new();
    sb.clear_state();
    sb.mismatches = 0;
    sb.checked = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: extremes, HI/LO sequences, divide by zero, most negative by minus one.
    send_word({miu_pkg::OP_SPECIAL, 5'd1, 5'd2, 5'd3, 5'd31, miu_pkg::FN_SRA},
              0, 32'h8000_0000, 0);
    send_word({miu_pkg::OP_SPECIAL, 5'd1, 5'd2, 5'd0, 5'd0, miu_pkg::FN_SLL},
              0, 32'hFFFF_FFFF, 0);
    send_word({miu_pkg::OP_SPECIAL, 5'd1, 5'd2, 5'd4, 5'd0, miu_pkg::FN_MULT},
              32'h8000_0000, 32'h8000_0000, 0);
    send_word({miu_pkg::OP_SPECIAL, 5'd0, 5'd0, 5'd5, 5'd0, miu_pkg::FN_MFHI}, 0, 0, 0);
    send_word({miu_pkg::OP_SPECIAL, 5'd1, 5'd2, 5'd0, 5'd0, miu_pkg::FN_DIV},
              32'h8000_0000, 32'hFFFF_FFFF, 0);
    send_word({miu_pkg::OP_SPECIAL, 5'd0, 5'd0, 5'd6, 5'd0, miu_pkg::FN_MFLO}, 0, 0, 0);
    send_word({miu_pkg::OP_SPECIAL, 5'd1, 5'd2, 5'd0, 5'd0, miu_pkg::FN_DIVU},
              32'd77, 32'd0, 0);
    send_word({miu_pkg::OP_SPECIAL, 5'd0, 5'd0, 5'd7, 5'd0, miu_pkg::FN_MFHI}, 0, 0, 0);
    send_word({miu_pkg::OP_SPECIAL, 5'd1, 5'd2, 5'd0, 5'd0, miu_pkg::FN_DIV},
              32'hFFFF_FFF9, 32'd2, 0);
    send_word({miu_pkg::OP_SPECIAL, 5'd0, 5'd0, 5'd7, 5'd0, miu_pkg::FN_MFHI}, 0, 0, 0);
    send_word({miu_pkg::OP_SPECIAL, 5'd1, 5'd2, 5'd9, 5'd0, miu_pkg::FN_ADD},
              32'h7FFF_FFFF, 1, 0);
    send_word({miu_pkg::OP_SPECIAL, 5'd1, 5'd2, 5'd9, 5'd0, miu_pkg::FN_SLT},
              32'h8000_0000, 1, 0);
    send_word({miu_pkg::OP_SPECIAL, 5'd1, 5'd0, 5'd9, 5'd0, miu_pkg::FN_JALR},
              32'h1234_5678, 0, 32'hFFFF_FFFC);
    send_word({miu_pkg::OP_SPECIAL, 20'd0, miu_pkg::FN_SYSCALL}, 0, 0, 0);
    send_word({miu_pkg::OP_SPECIAL, 20'd0, 6'h3F}, 1, 1, 1);
    send_word({miu_pkg::OP_REGIMM, 5'd1, 5'd5, 16'h0}, 0, 0, 0);
    send_word({miu_pkg::OP_BGTZ, 5'd1, 5'd0, 16'h8000}, 0, 0, 32'h10);
    send_word({miu_pkg::OP_BLEZ, 5'd1, 5'd0, 16'h7FFF}, 32'h8000_0000, 0, 0);
    send_word({miu_pkg::OP_JAL, 26'h3FF_FFFF}, 0, 0, 32'hEFFF_FFFC);
    send_word({miu_pkg::OP_ADDI, 5'd1, 5'd0, 16'h8000}, 32'h8000_0000, 0, 0);
    send_word({miu_pkg::OP_SLTI, 5'd1, 5'd2, 16'hFFFF}, 32'hFFFF_FFFE, 0, 0);
    send_word({miu_pkg::OP_LUI, 5'd0, 5'd31, 16'hFFFF}, 0, 0, 0);
    send_word({miu_pkg::OP_SB, 5'd1, 5'd2, 16'hFFFF}, 0, 32'hFFFF_FFFF, 0);
    send_word({miu_pkg::OP_SH, 5'd1, 5'd2, 16'h0001}, 32'hFFFF_FFFF, 32'hABCD_1234, 0);
    send_word({6'h3F, 26'h0}, 0, 0, 0);
    // Pause until every result word is back.
    drain();
    repeat (500) send_random();
    send_idle_pct = 72;
    recv_idle_pct = 37;
    repeat (500) send_random();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 1'b1;
    fork
      repeat (200) @(posedge clk);
      repeat (5) send_random();
    join_any
    recv_hold = 1'b0;
    wait fork;
    repeat (545) send_random();
    drain();
    $display("Sent %0d instruction words, checked %0d result words, covering ALU, HI/LO,",
             sent, sb.checked);
    $display("branch, jump, load/store and unsupported encodings under varied stalls.");
    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
